FILE: rtl/core/stsolve_pkg.sv
// ----------------------------------------------------------------------------
// stsolve_pkg
// Shared types, constants and fixed-point helpers for the Toeplitz solver.
// ----------------------------------------------------------------------------
package stsolve_pkg;

	// data formats
	localparam int DATA_W    = 32;
	localparam int STORE_W   = 48;
	localparam int ACC_W     = 64;
	localparam int FRAC_BITS = 24;

	// status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_NOT_PD = 1'b1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] autocorr_value;
		logic signed [DATA_W-1:0] rhs_value;
		logic                     last_element;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] solution_value;
		logic                     status;
		logic                     last_result;
	} out_beat_t;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic                    busy;
		logic signed [ACC_W-1:0] result;
	} mul_rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] num;
		logic signed [ACC_W-1:0] den;
		logic                    flip;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic                    busy;
		logic signed [ACC_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT_RD,
		ST_INIT,
		ST_X0_WAIT,
		ST_K_TOP,
		ST_R_INIT,
		ST_R_LOOP,
		ST_R_MUL,
		ST_R_WAIT,
		ST_RC_WAIT,
		ST_ERR_WAIT,
		ST_P_LOOP,
		ST_P_RDJ,
		ST_P_MUL1,
		ST_P_WAIT1,
		ST_P_WAIT2,
		ST_P_WRI,
		ST_MID_MUL,
		ST_MID_WAIT,
		ST_X_INIT,
		ST_X_SUM,
		ST_X_LOOP,
		ST_X_MUL,
		ST_X_WAIT,
		ST_XK_WAIT,
		ST_U_LOOP,
		ST_U_MUL,
		ST_U_WAIT,
		ST_OUT_RD,
		ST_OUT,
		ST_FAIL
	} state_t;

	// magnitude of a two's complement word
	function automatic logic [ACC_W-1:0] umag(input logic signed [ACC_W-1:0] x);
		return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
	endfunction

	// signed value from a magnitude, saturated
	function automatic logic signed [ACC_W-1:0] from_mag(input logic [ACC_W-1:0] m,
			input logic neg);
		if (!neg) begin
			return m[ACC_W-1] ? ACC_MAX : $signed(m);
		end
		return m[ACC_W-1] ? ACC_MIN : -$signed(m);
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = a + b;
		if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W-1:0] s;
		s = a - b;
		if (a[ACC_W-1] != b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
			return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end
		return s;
	endfunction

	// 64 to 48 bit saturation
	function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [ACC_W-1:0] x);
		if (!x[ACC_W-1] && (|x[ACC_W-2:STORE_W-1])) begin
			return {1'b0, {(STORE_W-1){1'b1}}};
		end
		if (x[ACC_W-1] && !(&x[ACC_W-2:STORE_W-1])) begin
			return {1'b1, {(STORE_W-1){1'b0}}};
		end
		return x[STORE_W-1:0];
	endfunction

	// 48 bit to output width saturation
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [STORE_W-1:0] x);
		if (!x[STORE_W-1] && (|x[STORE_W-2:DATA_W-1])) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
		if (x[STORE_W-1] && !(&x[STORE_W-2:DATA_W-1])) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end
		return x[DATA_W-1:0];
	endfunction

	// saturated negation in 48 bits
	function automatic logic signed [STORE_W-1:0] neg_store(input logic signed [STORE_W-1:0] x);
		if (x == {1'b1, {(STORE_W-1){1'b0}}}) begin
			return {1'b0, {(STORE_W-1){1'b1}}};
		end
		return -x;
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_data(input logic signed [DATA_W-1:0] x);
		return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] ext_store(input logic signed [STORE_W-1:0] x);
		return {{(ACC_W-STORE_W){x[STORE_W-1]}}, x};
	endfunction

endpackage

FILE: rtl/core/stsolve_mul.sv
// ----------------------------------------------------------------------------
// stsolve_mul
// Sequential 64x64 fixed-point multiplier, one 32x32 partial product a cycle,
// round to nearest on the fraction and saturate to 64 bits.
// ----------------------------------------------------------------------------
module stsolve_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stsolve_pkg::mul_req_t req,
	output stsolve_pkg::mul_rsp_t rsp
);
	import stsolve_pkg::*;

	localparam int          HALF_W  = ACC_W / 2;
	localparam int          PROD_W  = 2 * ACC_W;
	localparam logic [2:0]  STEP_FIN = 3'd4;

	logic               busy_q;
	logic               done_q;
	logic [2:0]         step_q;
	logic [ACC_W-1:0]   ma_q;
	logic [ACC_W-1:0]   mb_q;
	logic               neg_q;
	logic [PROD_W-1:0]  acc_q;
	logic signed [ACC_W-1:0] res_q;

	logic [HALF_W-1:0]  a_part;
	logic [HALF_W-1:0]  b_part;
	logic [ACC_W-1:0]   pp;
	logic [PROD_W-1:0]  pp_shift;
	logic [ACC_W-1:0]   mag;

	// partial product select
	always_comb begin
		a_part = step_q[0] ? ma_q[ACC_W-1:HALF_W] : ma_q[HALF_W-1:0];
		b_part = step_q[1] ? mb_q[ACC_W-1:HALF_W] : mb_q[HALF_W-1:0];
		pp     = ACC_W'(a_part) * ACC_W'(b_part);
		if (step_q[0] && step_q[1]) begin
			pp_shift = {pp, {ACC_W{1'b0}}};
		end else if (step_q[0] || step_q[1]) begin
			pp_shift = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
		end else begin
			pp_shift = {{ACC_W{1'b0}}, pp};
		end
		mag = (|acc_q[PROD_W-1:ACC_W+FRAC_BITS]) ? {ACC_W{1'b1}}
			: acc_q[ACC_W+FRAC_BITS-1:FRAC_BITS];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_FIN) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	// datapath, rounding constant preloaded into the accumulator
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			ma_q  <= umag(req.a);
			mb_q  <= umag(req.b);
			neg_q <= req.a[ACC_W-1] ^ req.b[ACC_W-1];
			acc_q <= PROD_W'(1) << (FRAC_BITS - 1);
		end else if (busy_q) begin
			if (step_q == STEP_FIN) begin
				res_q <= from_mag(mag, neg_q);
			end else begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.busy   = busy_q;
	assign rsp.result = res_q;

endmodule

FILE: rtl/core/stsolve_div.sv
// ----------------------------------------------------------------------------
// stsolve_div
// Restoring divider, one quotient bit a cycle: num * 2^24 / den, truncated,
// sign flip on request, saturated to 64 bits.
// ----------------------------------------------------------------------------
module stsolve_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stsolve_pkg::div_req_t req,
	output stsolve_pkg::div_rsp_t rsp
);
	import stsolve_pkg::*;

	localparam int         DVD_W     = ACC_W + FRAC_BITS;
	localparam logic [6:0] LAST_STEP = 7'(DVD_W - 1);
	localparam logic [6:0] QUOT_TOP  = 7'(ACC_W);

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [6:0]         cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [ACC_W-1:0]   r_q;
	logic [ACC_W-1:0]   q_q;
	logic [ACC_W-1:0]   d_q;
	logic               ovf_q;
	logic               neg_q;
	logic signed [ACC_W-1:0] res_q;

	logic [ACC_W-1:0]   r_shift;
	logic               ge;

	// trial subtract
	always_comb begin
		r_shift = {r_q[ACC_W-2:0], dvd_q[DVD_W-1]};
		ge      = r_shift >= d_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				if (fin_q) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b0;
					done_q <= 1'b1;
				end else if (cnt_q == '0) begin
					fin_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= {umag(req.num), {FRAC_BITS{1'b0}}};
			r_q   <= '0;
			q_q   <= '0;
			d_q   <= req.den;
			ovf_q <= 1'b0;
			neg_q <= req.num[ACC_W-1] ^ req.flip;
		end else if (busy_q) begin
			if (fin_q) begin
				res_q <= from_mag(ovf_q ? {ACC_W{1'b1}} : q_q, neg_q);
			end else begin
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				r_q   <= ge ? r_shift - d_q : r_shift;
				q_q   <= {q_q[ACC_W-2:0], ge};
				if (cnt_q >= QUOT_TOP && ge) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quot = res_q;

endmodule

FILE: rtl/core/symmetric_toeplitz_solver_core.sv
// N loads at one beat per cycle, then the solve of order N, then N result beats,
//   or a single failure beat if the recursion finds T not positive definite.
// The solve time is set by the shared multiplier, one product at a time, and
//   the bit-serial divider, which is used twice per order step.
// Reset clears the sequencer, element count and output valid; the memories are
//   not cleared, a solve only reads entries written in its own load and solve.
// ----------------------------------------------------------------------------
// symmetric_toeplitz_solver_core
// Levinson recursion for T x = b with symmetric Toeplitz T, Q7.24 in and out,
// state held in row, rhs, solution and predictor memories.
// ----------------------------------------------------------------------------
module symmetric_toeplitz_solver_core #(
	parameter int MAX_ORDER = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  stsolve_pkg::in_beat_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output stsolve_pkg::out_beat_t out_data
);
	import stsolve_pkg::*;

	localparam int             AW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam logic [AW:0]    MAXC = (AW+1)'(MAX_ORDER);
	localparam logic [AW:0]    ONE  = (AW+1)'(1);

	// memories
	logic [DATA_W-1:0]  row_mem  [MAX_ORDER];
	logic [DATA_W-1:0]  rhs_mem  [MAX_ORDER];
	logic [STORE_W-1:0] sol_mem  [MAX_ORDER];
	logic [STORE_W-1:0] pred_mem [MAX_ORDER];

	logic signed [DATA_W-1:0]  row_rd_q;
	logic signed [DATA_W-1:0]  rhs_rd_q;
	logic signed [STORE_W-1:0] sol_rd_q;
	logic signed [STORE_W-1:0] pred_rd_q;

	logic [AW-1:0]  row_raddr;
	logic [AW-1:0]  rhs_raddr;
	logic [AW-1:0]  sol_raddr;
	logic [AW-1:0]  pred_raddr;
	logic           load_we;
	logic           sol_we;
	logic [AW-1:0]  sol_waddr;
	logic [STORE_W-1:0] sol_wdata;
	logic           pred_we;
	logic [AW-1:0]  pred_waddr;
	logic [STORE_W-1:0] pred_wdata;

	// sequencer state
	state_t         state_q, state_d;
	logic [AW:0]    cnt_q, cnt_d;
	logic [AW:0]    n_q, n_d;
	logic [AW-1:0]  k_q, k_d;
	logic signed [AW:0] i_q, i_d;
	logic signed [AW:0] j_q, j_d;
	logic signed [ACC_W-1:0]   err_q, err_d;
	logic signed [ACC_W-1:0]   sum_q, sum_d;
	logic signed [STORE_W-1:0] rc_q, rc_d;
	logic signed [STORE_W-1:0] xk_q, xk_d;
	logic signed [STORE_W-1:0] tai_q, tai_d;
	logic signed [STORE_W-1:0] taj_q, taj_d;
	logic signed [STORE_W-1:0] t_q, t_d;

	logic [AW:0]        kp1;
	logic signed [AW:0] ks;
	logic signed [ACC_W-1:0] e_new;
	logic signed [STORE_W-1:0] quot_st;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// output register
	logic      out_valid_q;
	out_beat_t out_q;
	logic      out_load;
	out_beat_t out_beat;
	logic      out_free;

	stsolve_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	stsolve_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (load_we) begin
			row_mem[cnt_q[AW-1:0]] <= in_data.autocorr_value;
			rhs_mem[cnt_q[AW-1:0]] <= in_data.rhs_value;
		end
		if (sol_we) begin
			sol_mem[sol_waddr] <= sol_wdata;
		end
		if (pred_we) begin
			pred_mem[pred_waddr] <= pred_wdata;
		end
		row_rd_q  <= row_mem[row_raddr];
		rhs_rd_q  <= rhs_mem[rhs_raddr];
		sol_rd_q  <= sol_mem[sol_raddr];
		pred_rd_q <= pred_mem[pred_raddr];
	end

	assign kp1      = {1'b0, k_q} + ONE;
	assign ks       = $signed({1'b0, k_q});
	assign e_new    = sat_add(err_q, mul_rsp.result);
	assign quot_st  = sat_store(div_rsp.quot);
	assign out_free = !out_valid_q || out_ready;

	// next state and controls
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		n_d        = n_q;
		k_d        = k_q;
		i_d        = i_q;
		j_d        = j_q;
		err_d      = err_q;
		sum_d      = sum_q;
		rc_d       = rc_q;
		xk_d       = xk_q;
		tai_d      = tai_q;
		taj_d      = taj_q;
		t_d        = t_q;
		row_raddr  = '0;
		rhs_raddr  = '0;
		sol_raddr  = i_q[AW-1:0];
		pred_raddr = i_q[AW-1:0];
		load_we    = 1'b0;
		sol_we     = 1'b0;
		sol_waddr  = i_q[AW-1:0];
		sol_wdata  = '0;
		pred_we    = 1'b0;
		pred_waddr = i_q[AW-1:0];
		pred_wdata = '0;
		mul_req    = '0;
		div_req    = '0;
		out_load   = 1'b0;
		out_beat   = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cnt_q < MAXC) begin
						load_we = 1'b1;
						cnt_d   = cnt_q + ONE;
					end
					if (in_data.last_element) begin
						n_d     = (cnt_q < MAXC) ? cnt_q + ONE : cnt_q;
						cnt_d   = '0;
						state_d = ST_INIT_RD;
					end
				end
			end
			ST_INIT_RD: begin
				state_d = ST_INIT;
			end
			ST_INIT: begin
				err_d = ext_data(row_rd_q);
				if (ext_data(row_rd_q) <= 0) begin
					state_d = ST_FAIL;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = ext_data(rhs_rd_q);
					div_req.den   = ext_data(row_rd_q);
					div_req.flip  = 1'b0;
					state_d       = ST_X0_WAIT;
				end
			end
			ST_X0_WAIT: begin
				if (div_rsp.done) begin
					sol_we    = 1'b1;
					sol_waddr = '0;
					sol_wdata = quot_st;
					k_d       = '0;
					state_d   = ST_K_TOP;
				end
			end
			// next order step, or done
			ST_K_TOP: begin
				if (kp1 >= n_q) begin
					i_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					row_raddr = kp1[AW-1:0];
					state_d   = ST_R_INIT;
				end
			end
			ST_R_INIT: begin
				sum_d   = ext_data(row_rd_q);
				i_d     = '0;
				state_d = ST_R_LOOP;
			end
			// reflection numerator
			ST_R_LOOP: begin
				if (i_q < ks) begin
					row_raddr  = k_q - i_q[AW-1:0];
					pred_raddr = i_q[AW-1:0];
					state_d    = ST_R_MUL;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = sum_q;
					div_req.den   = err_q;
					div_req.flip  = 1'b1;
					state_d       = ST_RC_WAIT;
				end
			end
			ST_R_MUL: begin
				mul_req.start = 1'b1;
				mul_req.a     = ext_data(row_rd_q);
				mul_req.b     = ext_store(pred_rd_q);
				state_d       = ST_R_WAIT;
			end
			ST_R_WAIT: begin
				if (mul_rsp.done) begin
					sum_d   = sat_sub(sum_q, mul_rsp.result);
					i_d     = i_q + ONE;
					state_d = ST_R_LOOP;
				end
			end
			ST_RC_WAIT: begin
				if (div_rsp.done) begin
					rc_d          = quot_st;
					mul_req.start = 1'b1;
					mul_req.a     = ext_store(quot_st);
					mul_req.b     = sum_q;
					state_d       = ST_ERR_WAIT;
				end
			end
			// prediction error update
			ST_ERR_WAIT: begin
				if (mul_rsp.done) begin
					if (e_new <= 0) begin
						state_d = ST_FAIL;
					end else begin
						err_d      = e_new;
						pred_we    = 1'b1;
						pred_waddr = k_q;
						pred_wdata = neg_store(rc_q);
						i_d        = '0;
						j_d        = ks - $signed(ONE);
						state_d    = ST_P_LOOP;
					end
				end
			end
			// predictor update in symmetric pairs
			ST_P_LOOP: begin
				pred_raddr = i_q[AW-1:0];
				if (i_q < j_q) begin
					state_d = ST_P_RDJ;
				end else if (i_q == j_q) begin
					state_d = ST_MID_MUL;
				end else begin
					state_d = ST_X_INIT;
				end
			end
			ST_P_RDJ: begin
				tai_d      = pred_rd_q;
				pred_raddr = j_q[AW-1:0];
				state_d    = ST_P_MUL1;
			end
			ST_P_MUL1: begin
				taj_d         = pred_rd_q;
				mul_req.start = 1'b1;
				mul_req.a     = ext_store(rc_q);
				mul_req.b     = ext_store(pred_rd_q);
				state_d       = ST_P_WAIT1;
			end
			ST_P_WAIT1: begin
				if (mul_rsp.done) begin
					t_d           = sat_store(sat_add(ext_store(tai_q), mul_rsp.result));
					mul_req.start = 1'b1;
					mul_req.a     = ext_store(rc_q);
					mul_req.b     = ext_store(tai_q);
					state_d       = ST_P_WAIT2;
				end
			end
			ST_P_WAIT2: begin
				if (mul_rsp.done) begin
					pred_we    = 1'b1;
					pred_waddr = j_q[AW-1:0];
					pred_wdata = sat_store(sat_add(ext_store(taj_q), mul_rsp.result));
					state_d    = ST_P_WRI;
				end
			end
			ST_P_WRI: begin
				pred_we    = 1'b1;
				pred_waddr = i_q[AW-1:0];
				pred_wdata = t_q;
				i_d        = i_q + ONE;
				j_d        = j_q - ONE;
				state_d    = ST_P_LOOP;
			end
			// middle entry of an odd length predictor
			ST_MID_MUL: begin
				tai_d         = pred_rd_q;
				mul_req.start = 1'b1;
				mul_req.a     = ext_store(rc_q);
				mul_req.b     = ext_store(pred_rd_q);
				state_d       = ST_MID_WAIT;
			end
			ST_MID_WAIT: begin
				if (mul_rsp.done) begin
					pred_we    = 1'b1;
					pred_waddr = i_q[AW-1:0];
					pred_wdata = sat_store(sat_add(ext_store(tai_q), mul_rsp.result));
					state_d    = ST_X_INIT;
				end
			end
			// new solution entry
			ST_X_INIT: begin
				rhs_raddr = kp1[AW-1:0];
				state_d   = ST_X_SUM;
			end
			ST_X_SUM: begin
				sum_d   = ext_data(rhs_rd_q);
				i_d     = '0;
				j_d     = $signed(kp1);
				state_d = ST_X_LOOP;
			end
			ST_X_LOOP: begin
				if (i_q <= ks) begin
					sol_raddr = i_q[AW-1:0];
					row_raddr = j_q[AW-1:0];
					state_d   = ST_X_MUL;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = sum_q;
					div_req.den   = err_q;
					div_req.flip  = 1'b0;
					state_d       = ST_XK_WAIT;
				end
			end
			ST_X_MUL: begin
				mul_req.start = 1'b1;
				mul_req.a     = ext_store(sol_rd_q);
				mul_req.b     = ext_data(row_rd_q);
				state_d       = ST_X_WAIT;
			end
			ST_X_WAIT: begin
				if (mul_rsp.done) begin
					sum_d   = sat_sub(sum_q, mul_rsp.result);
					i_d     = i_q + ONE;
					j_d     = j_q - ONE;
					state_d = ST_X_LOOP;
				end
			end
			ST_XK_WAIT: begin
				if (div_rsp.done) begin
					xk_d      = quot_st;
					sol_we    = 1'b1;
					sol_waddr = kp1[AW-1:0];
					sol_wdata = quot_st;
					i_d       = '0;
					j_d       = ks;
					state_d   = ST_U_LOOP;
				end
			end
			// back substitution into earlier solution entries
			ST_U_LOOP: begin
				if (i_q <= ks) begin
					sol_raddr  = i_q[AW-1:0];
					pred_raddr = j_q[AW-1:0];
					state_d    = ST_U_MUL;
				end else begin
					k_d     = k_q + AW'(1);
					state_d = ST_K_TOP;
				end
			end
			ST_U_MUL: begin
				tai_d         = sol_rd_q;
				mul_req.start = 1'b1;
				mul_req.a     = ext_store(xk_q);
				mul_req.b     = ext_store(pred_rd_q);
				state_d       = ST_U_WAIT;
			end
			ST_U_WAIT: begin
				if (mul_rsp.done) begin
					sol_we    = 1'b1;
					sol_waddr = i_q[AW-1:0];
					sol_wdata = sat_store(sat_sub(ext_store(tai_q), mul_rsp.result));
					i_d       = i_q + ONE;
					j_d       = j_q - ONE;
					state_d   = ST_U_LOOP;
				end
			end
			// result beats
			ST_OUT_RD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load                = 1'b1;
					out_beat.solution_value = sat_data(sol_rd_q);
					out_beat.status         = STATUS_OK;
					out_beat.last_result    = ($unsigned(i_q) == n_q - ONE);
					if ($unsigned(i_q) == n_q - ONE) begin
						state_d = ST_LOAD;
					end else begin
						i_d     = i_q + ONE;
						state_d = ST_OUT_RD;
					end
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					out_load                = 1'b1;
					out_beat.solution_value = '0;
					out_beat.status         = STATUS_NOT_PD;
					out_beat.last_result    = 1'b1;
					state_d                 = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			n_q     <= n_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		err_q <= err_d;
		sum_q <= sum_d;
		rc_q  <= rc_d;
		xk_q  <= xk_d;
		tai_q <= tai_d;
		taj_q <= taj_d;
		t_q   <= t_d;
		if (out_load) begin
			out_q <= out_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared units are only started when free
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a failure beat is a single zero beat that closes the solve
	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STATUS_NOT_PD
			|-> out_data.last_result && out_data.solution_value == '0)
		else $error("malformed failure beat");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXC)
		else $error("element count beyond depth");

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> $unsigned(i_q) < n_q)
		else $error("result index beyond order");

endmodule

FILE: tb/sv/stsolve_checker.sv
// ----------------------------------------------------------------------------
// stsolve_checker
// Watches both channels of the Toeplitz solver, recomputes each solve with an
// independent fixed-point Levinson recursion and compares every result beat.
// ----------------------------------------------------------------------------
module stsolve_checker #(
	parameter int MAX_ORDER = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  stsolve_pkg::in_beat_t  in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  stsolve_pkg::out_beat_t out_data,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import stsolve_pkg::*;

	localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint Q_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

	// shadow state of the solver
	longint    row_mem  [MAX_ORDER];
	longint    rhs_mem  [MAX_ORDER];
	longint    x_mem    [MAX_ORDER];
	longint    pred_mem [MAX_ORDER];
	longint    pred_err;
	int        loaded;
	out_beat_t solution_q[$];

	assign pending = solution_q.size();

	// fixed-point helpers
	function automatic longint clamp(input longint x, input int w);
		longint lim;
		lim = (64'sd1 <<< (w - 1)) - 1;
		if (x > lim) return lim;
		if (x < -lim - 1) return -lim - 1;
		return x;
	endfunction

	function automatic longint add_s(input longint a, input longint b);
		longint r;
		r = a + b;
		if (a >= 0 && b >= 0 && r < 0) return Q_MAX;
		if (a < 0 && b < 0 && r >= 0) return Q_MIN;
		return r;
	endfunction

	function automatic longint sub_s(input longint a, input longint b);
		longint r;
		r = a - b;
		if (a >= 0 && b < 0 && r < 0) return Q_MAX;
		if (a < 0 && b >= 0 && r >= 0) return Q_MIN;
		return r;
	endfunction

	function automatic longint unsigned mag(input longint x);
		return x < 0 ? longint'(unsigned'(-x)) : x;
	endfunction

	function automatic longint signed_of(input longint unsigned m, input bit neg);
		if (!neg) return m[63] ? Q_MAX : longint'(m);
		if (m[63]) return Q_MIN;
		return -longint'(m);
	endfunction

	// product rounded half away from zero back to 24 fraction bits
	function automatic longint mul_q(input longint a, input longint b);
		logic [127:0] p;
		longint unsigned r;
		p = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << (FRAC_BITS - 1));
		r = (|p[127:64+FRAC_BITS]) ? '1 : p[63+FRAC_BITS:FRAC_BITS];
		return signed_of(r, (a < 0) != (b < 0));
	endfunction

	// truncated quotient num*2^24/den, den positive
	function automatic longint div_q(input longint num, input longint den, input bit flip);
		logic [127:0] q;
		longint unsigned r;
		q = (128'(mag(num)) << FRAC_BITS) / 128'(den);
		r = (|q[127:64]) ? '1 : q[63:0];
		return signed_of(r, (num < 0) != flip);
	endfunction

	// levinson recursion over the loaded elements
	task automatic run_levinson(input int n, output bit ok);
		int     k, i, j;
		longint acc, rc, t;
		ok = 0;
		pred_err = row_mem[0];
		if (pred_err <= 0) return;
		x_mem[0] = clamp(div_q(rhs_mem[0], pred_err, 0), STORE_W);
		for (k = 0; k < n - 1; k++) begin
			acc = row_mem[k+1];
			for (i = 0; i < k; i++)
				acc = sub_s(acc, mul_q(row_mem[k-i], pred_mem[i]));
			rc = clamp(div_q(acc, pred_err, 1), STORE_W);
			pred_err = add_s(pred_err, mul_q(rc, acc));
			if (pred_err <= 0) return;
			pred_mem[k] = clamp(-rc, STORE_W);
			// symmetric predictor update
			i = 0;
			j = k - 1;
			while (i < j) begin
				t = clamp(add_s(pred_mem[i], mul_q(rc, pred_mem[j])), STORE_W);
				pred_mem[j] = clamp(add_s(pred_mem[j], mul_q(rc, pred_mem[i])), STORE_W);
				pred_mem[i] = t;
				i++;
				j--;
			end
			if (i == j)
				pred_mem[i] = clamp(add_s(pred_mem[i], mul_q(rc, pred_mem[i])), STORE_W);
			// solution update
			acc = rhs_mem[k+1];
			for (i = 0; i <= k; i++)
				acc = sub_s(acc, mul_q(x_mem[i], row_mem[k+1-i]));
			x_mem[k+1] = clamp(div_q(acc, pred_err, 0), STORE_W);
			for (i = 0; i <= k; i++)
				x_mem[i] = clamp(sub_s(x_mem[i], mul_q(x_mem[k+1], pred_mem[k-i])), STORE_W);
		end
		ok = 1;
	endtask

	// input beats: load, and solve on the last one
	always @(posedge clk or negedge arst_n) begin
		bit        ok;
		int        n;
		out_beat_t e;
		if (!arst_n) begin
			loaded = 0;
		end else if (in_valid && in_ready) begin
			if (loaded < MAX_ORDER) begin
				row_mem[loaded] = longint'(in_data.autocorr_value);
				rhs_mem[loaded] = longint'(in_data.rhs_value);
				loaded++;
			end
			if (in_data.last_element) begin
				n = loaded;
				loaded = 0;
				run_levinson(n, ok);
				if (!ok) begin
					e.solution_value = '0;
					e.status = STATUS_NOT_PD;
					e.last_result = 1'b1;
					solution_q.push_back(e);
				end else begin
					for (int k = 0; k < n; k++) begin
						e.solution_value = DATA_W'(clamp(x_mem[k], DATA_W));
						e.status = STATUS_OK;
						e.last_result = (k == n - 1);
						solution_q.push_back(e);
					end
				end
			end
		end
	end

	// result beats against the oldest expectation
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (solution_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, out_data);
				fail_count++;
			end else begin
				e = solution_q.pop_front();
				if (out_data.solution_value !== e.solution_value) begin
					$display("%0t: solution_value expected %h actual %h", $time,
						e.solution_value, out_data.solution_value);
					fail_count++;
				end
				if (out_data.status !== e.status) begin
					$display("%0t: status expected %b actual %b", $time,
						e.status, out_data.status);
					fail_count++;
				end
				if (out_data.last_result !== e.last_result) begin
					$display("%0t: last_result expected %b actual %b", $time,
						e.last_result, out_data.last_result);
					fail_count++;
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_symmetric_toeplitz_solver_core.sv
// ----------------------------------------------------------------------------
// tb_symmetric_toeplitz_solver_core
// Drives element sequences into the Toeplitz solver under varying idle and
// stall patterns; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_symmetric_toeplitz_solver_core;
	import stsolve_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ORDER  = 64;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int WDOG_LIMIT = 300000;
	localparam int HOLD_LEN   = 3000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;
	int        fail_count;
	int        pending;

	int        idle_pct = 0;
	int        stall_pct = 0;
	int        hold_requests = 0;
	int        items_sent = 0;
	int        quiet_cycles = 0;

	symmetric_toeplitz_solver_core #(
		.MAX_ORDER (MAX_ORDER)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	stsolve_checker #(
		.MAX_ORDER (MAX_ORDER)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one element pair, with random idle cycles ahead of it
	task automatic send_beat(input int row, input int rhs, input bit last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{autocorr_value: row, rhs_value: rhs, last_element: last};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// a whole system; well-formed ones are diagonally dominant
	task automatic send_system(input int n, input bit well);
		int diag, span, v, b;
		diag = $urandom_range(ONE / 2, 4 * ONE);
		span = diag / (2 * n);
		for (int i = 0; i < n; i++) begin
			if (!well) begin
				v = $urandom;
				b = $urandom;
			end else begin
				v = (i == 0) ? diag : $urandom_range(span, 0);
				if (i != 0 && $urandom_range(1)) v = -v;
				b = $urandom_range(1) ? $urandom : $urandom_range(4 * ONE) - 2 * ONE;
			end
			send_beat(v, b, i == n - 1);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic random_systems(input int count);
		int n;
		for (int s = 0; s < count; s++) begin
			n = $urandom_range(1, 8);
			if ($urandom_range(99) < 75) send_system(n, 1);
			else send_system($urandom_range(1, 4), 0);
		end
	endtask

	// stimulus
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: order one extremes and errors
		send_beat(ONE, 32'sh7FFF_FFFF, 1);
		send_beat(0, ONE, 1);
		send_beat(32'sh8000_0000, 32'sh8000_0000, 1);
		send_beat(1, 32'sh8000_0000, 1);
		send_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
		// not positive definite in the recursion, and exactly singular
		send_beat(ONE, ONE, 0);
		send_beat(ONE + ONE / 2, -ONE, 1);
		send_beat(ONE, ONE, 0);
		send_beat(-ONE, ONE, 1);
		// small orders, even and odd predictor midpoints
		send_beat(2 * ONE, ONE, 0);
		send_beat(-ONE / 2, -ONE, 0);
		send_beat(ONE / 4, 32'sh7FFF_FFFF, 1);
		send_system(4, 1);
		send_system(5, 1);
		@(negedge clk);
		in_valid <= 1'b0;

		// no idling, with a long receiver hold while input keeps coming
		random_systems(6);
		hold_requests++;
		random_systems(6);
		send_system(MAX_ORDER, 1);
		// more pairs than the stores hold
		send_system(MAX_ORDER + 2, 1);

		// sender mostly idle, then a pause until the block drains
		idle_pct = 72;
		random_systems(6);
		@(negedge clk);
		wait (pending == 0);

		// receiver mostly stalled
		idle_pct = 0;
		stall_pct = 72;
		random_systems(6);

		// both
		idle_pct = 36;
		stall_pct = 36;
		while (items_sent < 270) random_systems(1);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (500) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
